// ===== design/tsbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbs_pkg
// shared types and codes of the two-wire slave byte sequencer
// ----------------------------------------------------------------------------
package tsbs_pkg;

  localparam int unsigned AddrW   = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 24;

  // event kinds
  typedef enum logic {
    OP_START    = 1'b0,
    OP_OVERFLOW = 1'b1
  } opcode_t;

  // sda direction requests
  typedef enum logic [1:0] {
    DRIVE_NONE = 2'd0,
    DRIVE_OUT  = 2'd1,
    DRIVE_IN   = 2'd2
  } sda_drive_t;

  // protocol phases
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_ADDR      = 3'd1,
    ST_SEND      = 3'd2,
    ST_REQ_REPLY = 3'd3,
    ST_CHK_REPLY = 3'd4,
    ST_REQ_DATA  = 3'd5,
    ST_GET_DATA  = 3'd6,
    ST_REFUSED   = 3'd7
  } proto_state_t;

  // register indexes
  typedef enum logic {
    REG_OWN_ADDRESS = 1'b0
  } reg_index_t;

  localparam logic [ByteW-1:0] TxAck  = 8'h00;
  localparam logic [ByteW-1:0] TxNack = 8'hFF;

  typedef struct packed {
    opcode_t          opcode;
    logic [ByteW-1:0] rx_byte;
    logic             stop_seen;
    logic [ByteW-1:0] read_byte;
    logic             write_refused;
  } item_t;

  typedef struct packed {
    logic             load_tx;
    logic [ByteW-1:0] tx_byte;
    sda_drive_t       sda_drive;
    logic             shift_one_bit;
    logic             bus_release;
    logic             overflow_enable;
    logic             reset_read_offset;
    logic             reset_write_pointer;
    logic             read_strobe;
    logic             write_strobe;
  } result_t;

  typedef struct packed {
    proto_state_t state;
    logic         armed;
  } seq_state_t;

endpackage

// ===== design/twi_slave_byte_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twi_slave_byte_sequencer_unit
// byte-level two-wire slave sequencer with stream ports and apb config
// ----------------------------------------------------------------------------
// Each input item is one bus event (start condition or shift-counter overflow)
// and yields exactly one result item with the shift-register load, sda
// direction, bit-count, release and register-file strobe decisions. The unit
// takes one item per clock while the result register is empty or being taken:
// an item is captured in an input register, decided by one short stage of
// logic against the protocol state and armed flag, and moves into the result
// register once that register is empty or is being taken. The protocol state
// advances in the same cycle the item moves into the result register, so a
// new item may follow in the very next cycle and the pipeline keeps moving
// whenever the result register is empty or is being taken. The own address
// lives at byte address 0 of the apb port (reset value 8); write it only while
// no items are in flight.
// ----------------------------------------------------------------------------
module twi_slave_byte_sequencer_unit import tsbs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // event stream in
  input  logic                s_tvalid,
  output logic                s_tready,
  // rx_byte[7:0], stop_seen[8], read_byte[16:9], write_refused[17], zero fill
  input  logic [InDataW-1:0]  s_tdata,
  // opcode[0]
  input  logic [0:0]          s_tuser,
  // decision stream out
  output logic                m_tvalid,
  input  logic                m_tready,
  // load_tx[0], tx_byte[8:1], sda_drive[10:9], shift_one_bit[11],
  // bus_release[12], overflow_enable[13], reset_read_offset[14],
  // reset_write_pointer[15], read_strobe[16], write_strobe[17], zero fill
  output logic [OutDataW-1:0] m_tdata,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [AddrW-1:0] own_address;

  // input register
  logic       in_valid;
  item_t      in_item;
  // result register
  logic       out_valid;
  result_t    out_res;
  // protocol state
  seq_state_t seq;

  result_t    dec_res;
  seq_state_t dec_nxt;
  logic       advance;

  tsbs_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .own_address (own_address)
  );

  tsbs_decide u_decide (
    .item        (in_item),
    .cur         (seq),
    .own_address (own_address),
    .res         (dec_res),
    .nxt         (dec_nxt)
  );

  // item moves on when the result slot is free or being emptied
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      seq       <= '{state: ST_IDLE, armed: 1'b0};
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        seq       <= dec_nxt;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.opcode        <= opcode_t'(s_tuser[0]);
      in_item.rx_byte       <= s_tdata[7:0];
      in_item.stop_seen     <= s_tdata[8];
      in_item.read_byte     <= s_tdata[16:9];
      in_item.write_refused <= s_tdata[17];
    end
    if (advance) begin
      out_res <= dec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0,
                     out_res.write_strobe,
                     out_res.read_strobe,
                     out_res.reset_write_pointer,
                     out_res.reset_read_offset,
                     out_res.overflow_enable,
                     out_res.bus_release,
                     out_res.shift_one_bit,
                     out_res.sda_drive,
                     out_res.tx_byte,
                     out_res.load_tx};

  // a shift-register load always comes with an sda direction change
  a_load_has_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.load_tx |-> out_res.sda_drive != DRIVE_NONE)
    else $error("load without sda direction");

  // releasing the bus leaves overflow events disabled
  a_release_disarms: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.bus_release |-> !out_res.overflow_enable)
    else $error("bus release left overflow enabled");

  // at most one register-file strobe per decision
  a_strobes_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({out_res.reset_read_offset, out_res.reset_write_pointer,
                            out_res.read_strobe, out_res.write_strobe}))
    else $error("several register-file strobes at once");

  // the armed flag reported matches the state the decision left behind
  a_enable_tracks_armed: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_res.overflow_enable == seq.armed)
    else $error("overflow enable disagrees with armed flag");

  // reset leaves overflow events ignored
  a_reset_disarmed: assert property (@(posedge clk)
    rst |=> !seq.armed && !out_valid)
    else $error("armed or valid after reset");

endmodule

// ===== design/tsbs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbs_cfg
// apb register block holding the own slave address
// ----------------------------------------------------------------------------
module tsbs_cfg import tsbs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [AddrW-1:0] own_address
);

  reg_index_t reg_sel;
  logic       addr_hit;

  assign reg_sel  = reg_index_t'(paddr[2]);
  assign addr_hit = (paddr[1:0] == 2'b00) && (reg_sel == REG_OWN_ADDRESS);
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= AddrW'(8);
    end else if (psel && penable && pwrite && pready && addr_hit) begin
      own_address <= pwdata[AddrW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_hit) begin
      prdata = {{(32-AddrW){1'b0}}, own_address};
    end
  end

endmodule

// ===== design/tsbs_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbs_decide
// per-event decision logic: result fields and next sequencer state
// ----------------------------------------------------------------------------
module tsbs_decide import tsbs_pkg::*; (
  input  item_t            item,
  input  seq_state_t       cur,
  input  logic [AddrW-1:0] own_address,
  output result_t          res,
  output seq_state_t       nxt
);

  logic [ByteW-1:0] addr_part;
  logic             addr_match;

  assign addr_part  = {item.rx_byte[ByteW-1:1], 1'b0};
  assign addr_match = (addr_part == {own_address, 1'b0}) || (addr_part == '0);

  always_comb begin
    res = '0;
    nxt = cur;
    if (item.opcode == OP_START) begin
      nxt.state     = ST_ADDR;
      res.sda_drive = DRIVE_IN;
      if (item.stop_seen) begin
        nxt.armed       = 1'b0;
        res.bus_release = 1'b1;
      end else begin
        nxt.armed = 1'b1;
      end
    end else if (cur.armed) begin
      unique case (cur.state)
        ST_ADDR: begin
          if (addr_match) begin
            if (item.rx_byte[0]) begin
              nxt.state             = ST_SEND;
              res.reset_read_offset = 1'b1;
            end else begin
              nxt.state               = ST_REQ_DATA;
              res.reset_write_pointer = 1'b1;
            end
            res.load_tx       = 1'b1;
            res.tx_byte       = TxAck;
            res.sda_drive     = DRIVE_OUT;
            res.shift_one_bit = 1'b1;
          end else begin
            res.bus_release = 1'b1;
            nxt.armed       = 1'b0;
          end
        end
        ST_SEND, ST_CHK_REPLY: begin
          // master nack ends the read transfer
          if (cur.state == ST_CHK_REPLY && item.rx_byte != '0) begin
            res.bus_release = 1'b1;
            nxt.armed       = 1'b0;
          end else begin
            res.load_tx     = 1'b1;
            res.tx_byte     = item.read_byte;
            res.sda_drive   = DRIVE_OUT;
            res.read_strobe = 1'b1;
            nxt.state       = ST_REQ_REPLY;
          end
        end
        ST_REQ_REPLY: begin
          res.load_tx       = 1'b1;
          res.tx_byte       = TxAck;
          res.sda_drive     = DRIVE_IN;
          res.shift_one_bit = 1'b1;
          nxt.state         = ST_CHK_REPLY;
        end
        ST_REQ_DATA: begin
          nxt.state     = ST_GET_DATA;
          res.sda_drive = DRIVE_IN;
        end
        ST_REFUSED: begin
          res.sda_drive = DRIVE_IN;
        end
        ST_GET_DATA: begin
          res.write_strobe  = 1'b1;
          res.load_tx       = 1'b1;
          res.sda_drive     = DRIVE_OUT;
          res.shift_one_bit = 1'b1;
          if (item.write_refused) begin
            res.tx_byte = TxNack;
            nxt.state   = ST_REFUSED;
          end else begin
            res.tx_byte = TxAck;
            nxt.state   = ST_REQ_DATA;
          end
        end
        ST_IDLE: begin
        end
      endcase
    end
    res.overflow_enable = nxt.armed;
  end

endmodule
